### rtl/crf_pkg.sv
// Shared types and constants for the clipped rectangle fill unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package crf_pkg;

  localparam int DEF_COLUMNS = 120;
  localparam int DEF_ROWS    = 60;
  localparam int QUEUE_DEPTH = 2;
  localparam int COORD_W     = 12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOWN  = 8'h76;  // 'v'
  localparam logic [7:0] CH_RIGHT = 8'h3e;  // '>'
  localparam logic [7:0] CH_LEFT  = 8'h3c;  // '<'

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } job_op_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [7:0]         material_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_code;
    logic       in_range;
  } out_item_t;

  // Classified job as it travels from front end to fill engine.
  typedef struct packed {
    job_op_t            op;
    logic [COORD_W-1:0] col0;
    logic [COORD_W-1:0] col1;
    logic [COORD_W-1:0] row0;
    logic [COORD_W-1:0] row1;
    logic [7:0]         mat;
    logic               ok;
  } job_t;

endpackage

### rtl/crf_front.sv
// Front end: decodes a command and clips the rectangle to the screen.
// Depends on crf_pkg. Purely combinational; feeds crf_queue.
`timescale 1ns / 1ps

module crf_front #(
  parameter int SCREEN_COLUMNS = crf_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = crf_pkg::DEF_ROWS
) (
  input  crf_pkg::in_item_t item,
  output logic              keep,
  output crf_pkg::job_t     job
);
  import crf_pkg::*;

  localparam logic signed [13:0] COLS_S = 14'(SCREEN_COLUMNS);
  localparam logic signed [13:0] ROWS_S = 14'(SCREEN_ROWS);

  logic signed [13:0] x, y, x0, y0, x1, y1, xe, ye;
  logic               empty_rect;
  logic               ok;

  always_comb begin
    x  = 14'(item.rect_x);
    y  = 14'(item.rect_y);
    xe = x + $signed({2'b00, item.rect_width});
    ye = y + $signed({2'b00, item.rect_height});
    x0 = (x < 0) ? 14'sd0 : x;
    y0 = (y < 0) ? 14'sd0 : y;
    x1 = (xe > COLS_S) ? COLS_S : xe;
    y1 = (ye > ROWS_S) ? ROWS_S : ye;
    empty_rect = (x1 <= x0) || (y1 <= y0);
    ok = (x >= 0) && (x < COLS_S) && (y >= 0) && (y < ROWS_S);
  end

  always_comb begin
    keep     = 1'b0;
    job.op   = OP_READ;
    job.col0 = '0;
    job.col1 = '0;
    job.row0 = '0;
    job.row1 = '0;
    job.mat  = item.material_code;
    job.ok   = ok;
    case (cmd_t'(item.cmd))
      CMD_CLEAR: begin
        keep     = 1'b1;
        job.op   = OP_CLEAR;
        job.col1 = COORD_W'(SCREEN_COLUMNS);
        job.row1 = COORD_W'(SCREEN_ROWS);
      end
      CMD_DRAW: begin
        keep     = !empty_rect;
        job.op   = OP_DRAW;
        job.col0 = x0[COORD_W-1:0];
        job.col1 = x1[COORD_W-1:0];
        job.row0 = y0[COORD_W-1:0];
        job.row1 = y1[COORD_W-1:0];
      end
      CMD_READ: begin
        keep   = 1'b1;
        job.op = OP_READ;
        // out-of-range reads point at cell zero; the result is masked anyway
        if (ok) begin
          job.col0 = x[COORD_W-1:0];
          job.row0 = y[COORD_W-1:0];
        end
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

### rtl/crf_queue.sv
// Short job queue between the front end and the fill engine.
// Depends on crf_pkg for the job type.
`timescale 1ns / 1ps

module crf_queue #(
  parameter int DEPTH = crf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crf_pkg::job_t push_job,
  input  logic          pop,
  output crf_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import crf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/crf_engine.sv
// Fill engine: owns the frame store, sweeps clear/draw jobs one cell per
// cycle and answers reads. Depends on crf_pkg; fed by crf_queue.
`timescale 1ns / 1ps

module crf_engine #(
  parameter int SCREEN_COLUMNS = crf_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = crf_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_avail,
  input  crf_pkg::job_t      job,
  output logic               job_take,
  output logic               res_strobe,
  output crf_pkg::out_item_t res
);
  import crf_pkg::*;

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETUP  = 5'b00010,
    S_FILL   = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  job_t               cur_r;
  logic [COORD_W-1:0] column_step_r, column_step_nxt;
  logic [COORD_W-1:0] row_step_r, row_step_nxt;
  logic [AW-1:0]      row_base_r, row_base_nxt;
  logic [7:0]         rdata_r;
  logic [7:0]         mem [CELLS];
  logic [2*COORD_W-1:0] prod;
  logic [AW-1:0]      addr;
  logic [7:0]         wdata;
  logic               last_col, last_row;

  assign job_take   = (state_r == S_IDLE) && job_avail;
  assign res_strobe = (state_r == S_RESULT);
  assign res        = {(cur_r.ok ? rdata_r : 8'h00), cur_r.ok};

  assign prod     = (2*COORD_W)'(cur_r.row0) * (2*COORD_W)'(SCREEN_COLUMNS);
  assign addr     = row_base_r + AW'(column_step_r);
  assign last_col = (column_step_r == COORD_W'(cur_r.col1 - 1'b1));
  assign last_row = (row_step_r == COORD_W'(cur_r.row1 - 1'b1));

  // border pattern: later rules win, so the row-0 corners are '>' and '<'
  always_comb begin
    wdata = cur_r.mat;
    if (cur_r.op == OP_CLEAR) begin
      wdata = CH_SPACE;
      if (row_step_r == '0) wdata = CH_DOWN;
      if (column_step_r == '0) wdata = CH_RIGHT;
      if (column_step_r == COORD_W'(SCREEN_COLUMNS - 1)) wdata = CH_LEFT;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    column_step_nxt = column_step_r;
    row_step_nxt    = row_step_r;
    row_base_nxt    = row_base_r;
    case (state_r)
      S_IDLE: begin
        if (job_avail) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        row_base_nxt    = prod[AW-1:0];
        column_step_nxt = cur_r.col0;
        row_step_nxt    = cur_r.row0;
        state_nxt       = (cur_r.op == OP_READ) ? S_READ : S_FILL;
      end
      S_FILL: begin
        if (last_col) begin
          column_step_nxt = cur_r.col0;
          if (last_row) begin
            column_step_nxt = '0;
            row_step_nxt    = '0;
            state_nxt       = S_IDLE;
          end else begin
            row_step_nxt = row_step_r + 1'b1;
            row_base_nxt = row_base_r + AW'(SCREEN_COLUMNS);
          end
        end else begin
          column_step_nxt = column_step_r + 1'b1;
        end
      end
      S_READ: begin
        column_step_nxt = '0;
        row_step_nxt    = '0;
        state_nxt       = S_RESULT;
      end
      S_RESULT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      column_step_r <= '0;
      row_step_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      column_step_r <= column_step_nxt;
      row_step_r    <= row_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    if (job_take) cur_r <= job;
  end

  // frame store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == S_FILL) mem[addr] <= wdata;
    if (state_r == S_READ) rdata_r <= mem[addr];
  end

endmodule

### rtl/clipped_rectangle_fill_unit.sv
// Top level of the clipped rectangle fill unit: front end, job queue and
// fill engine. Depends on crf_pkg, crf_front, crf_queue and crf_engine.
`timescale 1ns / 1ps

// Usage
// - Commands: drive in_data and raise start; a transfer happens at a rising
//   edge with start high and busy low. busy is high while the job queue is
//   full. Command 0 clears the screen to the border pattern, 1 fills a
//   clipped rectangle with material_code, 2 reads one cell, 3 is ignored.
// - Results: only reads answer. out_strobe is high for exactly one cycle
//   with out_data valid; the receiver must take it then.
// - Timing: every queued job is taken in S_IDLE and passes S_SETUP before
//   work starts. A draw then writes one on-screen cell per cycle, a clear
//   writes every cell of the screen. A read at an idle engine goes through
//   S_IDLE, S_SETUP and S_READ; out_strobe is high in S_RESULT after them.
//   The frame store's single write port sets the one-cell-per-cycle rate.
// - Draws with no on-screen cells and command 3 are dropped at the front
//   end and cost no engine time.
// - The front end keeps taking commands while the engine works, until the
//   queue of QUEUE_DEPTH jobs is full.
// - Reset (rst_n low, synchronous) empties the queue and idles the engine.
//   The frame store is not cleared: issue a clear before reading cells.

module clipped_rectangle_fill_unit #(
  parameter int SCREEN_COLUMNS = crf_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = crf_pkg::DEF_ROWS,
  parameter int QUEUE_DEPTH    = crf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  crf_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output crf_pkg::out_item_t out_data
);
  import crf_pkg::*;

  job_t front_job, queue_job;
  logic front_keep;
  logic q_push, q_pop, q_full, q_empty;

  crf_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .item(in_data),
    .keep(front_keep),
    .job (front_job)
  );

  assign q_push = start && !busy && front_keep;

  crf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(front_job),
    .pop     (q_pop),
    .pop_job (queue_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  crf_engine #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_empty),
    .job       (queue_job),
    .job_take  (q_pop),
    .res_strobe(out_strobe),
    .res       (out_data)
  );

  assign busy = q_full;

  // a read passes S_IDLE, S_SETUP and S_READ before S_RESULT, so strobes never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobes in back-to-back cycles");

  a_out_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.in_range) |-> (out_data.cell_code == 8'h00))
    else $error("out-of-range read returned a nonzero code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("queue or engine not idle after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("engine took a job from an empty queue");

endmodule
